### hw/rtl/periodic_task_table_scheduler_unit_macros.svh
// assertion macros for the periodic task table scheduler
// used by the top level; expects clk and rst_n in scope
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define PTTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ptts_pkg.sv
// shared types and constants for the periodic task table scheduler
// no dependencies
package ptts_pkg;

    // most fired words reported for one tick
    localparam int MAX_RESULTS = 16;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        K_FIRED    = 3'd0,
        K_NONE     = 3'd1,
        K_ADDED    = 3'd2,
        K_FULL     = 3'd3,
        K_REMOVED  = 3'd4,
        K_NOTFOUND = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_REM_RD,
        S_REM_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_REM_DONE,
        S_TICK_RD,
        S_TICK_CMP,
        S_CLN_CHK,
        S_FIN
    } state_t;

    // one table entry, 56 bits
    typedef struct packed {
        logic [7:0]  id;
        logic [14:0] period;
        logic        one_shot;
        logic [31:0] due;
    } entry_t;

endpackage

### hw/rtl/periodic_task_table_scheduler_unit.sv
// Periodic task table scheduler: holds up to TASKS periodic or one-shot tasks
// in a table with one write and one registered read port, and walks it one
// entry at a time with a shared 32-bit add and compare unit. One word is
// accepted at a time; in_ready is high only while idle. Add appends at the
// end of the table; remove scans for the first matching id and then does a
// swap-with-last; a tick walks every entry and then runs a cleanup pass that
// removes the one-shot entries that fired, each by a swap-with-last. Result
// words leave through an output register, and the walk pauses whenever a
// result is ready and that register is still full.
// depends on ptts_pkg, ptts_table and the assertion macro header
`include "periodic_task_table_scheduler_unit_macros.svh"

module periodic_task_table_scheduler_unit
    import ptts_pkg::*;
#(
    parameter int TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  task_id,
    input  logic [14:0] period,
    input  logic        one_shot,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  fired_id,
    output logic        last
);

    localparam int CW = $clog2(TASKS + 1);
    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    state_t state_reg, state_next;

    // latched input word
    action_t     act_reg, act_next;
    logic [7:0]  id_reg, id_next;
    logic [14:0] period_reg, period_next;
    logic        os_reg, os_next;
    logic [31:0] now_reg, now_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [TASKS-1:0] done_reg, done_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_id_reg, pend_id_next;

    // output register
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_id_reg;
    logic       out_last_reg;

    logic       push;
    kind_t      push_kind;
    logic [7:0] push_id;
    logic       push_last;
    logic       out_free;

    // table port
    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;

    logic [CW-1:0] count_m1;
    logic [IW-1:0] idx_a, last_a;
    logic [31:0]   due_sum;
    logic          fire;
    logic          report;

    ptts_table #(
        .DEPTH (TASKS),
        .AW    (IW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign count_m1 = count_reg - CW'(1);
    assign idx_a    = idx_reg[IW-1:0];
    assign last_a   = count_m1[IW-1:0];

    // shared add and compare unit for the tick walk
    assign due_sum = now_reg + {17'd0, rd_data.period};
    assign fire    = (rd_data.period == 15'd0) || (now_reg > rd_data.due);
    assign report  = fire && (n_reg < NW'(MAX_RESULTS));

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            done_reg       <= '0;
            pend_valid_reg <= 1'b0;
            act_reg        <= ACT_ADD;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            act_reg        <= act_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        period_reg  <= period_next;
        os_reg      <= os_next;
        now_reg     <= now_next;
        pend_id_reg <= pend_id_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        os_next         = os_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        push            = 1'b0;
        push_kind       = K_NONE;
        push_id         = 8'd0;
        push_last       = 1'b1;
        wr_en           = 1'b0;
        wr_addr         = idx_a;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = idx_a;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next         = task_id;
                    period_next     = period;
                    os_next         = one_shot;
                    now_next        = now;
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    case (action)
                        ACT_ADD:
                        begin
                            act_next   = ACT_ADD;
                            state_next = S_ADD;
                        end
                        ACT_REMOVE:
                        begin
                            act_next   = ACT_REMOVE;
                            state_next = S_REM_RD;
                        end
                        ACT_TICK:
                        begin
                            act_next   = ACT_TICK;
                            state_next = S_TICK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // append at the end of the table
            S_ADD:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == CW'(TASKS))
                    begin
                        push_kind = K_FULL;
                    end
                    else
                    begin
                        push_kind        = K_ADDED;
                        push_id          = id_reg;
                        wr_en            = 1'b1;
                        wr_addr          = count_reg[IW-1:0];
                        wr_data.id       = id_reg;
                        wr_data.period   = period_reg;
                        wr_data.one_shot = os_reg;
                        wr_data.due      = {17'd0, period_reg};
                        count_next       = count_reg + CW'(1);
                    end
                end
            end

            // linear search for the first matching id
            S_REM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (out_free)
                    begin
                        push       = 1'b1;
                        push_kind  = K_NOTFOUND;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_REM_CMP;
                end
            end

            S_REM_CMP:
            begin
                if (rd_data.id == id_reg)
                begin
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_REM_RD;
                end
            end

            // swap-with-last: fetch the last entry
            S_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_a;
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                wr_en             = 1'b1;
                done_next[idx_a]  = done_reg[last_a];
                done_next[last_a] = 1'b0;
                count_next        = count_m1;
                state_next        = (act_reg == ACT_REMOVE) ? S_REM_DONE : S_CLN_CHK;
            end

            S_REM_DONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_kind  = K_REMOVED;
                    push_id    = id_reg;
                    state_next = S_IDLE;
                end
            end

            // tick walk over every entry
            S_TICK_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    idx_next   = '0;
                    state_next = S_CLN_CHK;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_TICK_CMP;
                end
            end

            S_TICK_CMP:
            begin
                // the previous fired word leaves once another one is known
                if (!(report && pend_valid_reg && !out_free))
                begin
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            push      = 1'b1;
                            push_kind = K_FIRED;
                            push_id   = pend_id_reg;
                            push_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_data.id;
                        n_next          = n_reg + NW'(1);
                    end
                    if (fire)
                    begin
                        if (rd_data.one_shot)
                        begin
                            done_next[idx_a] = 1'b1;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_data.due = (rd_data.period == 15'd0) ? 32'd0 : due_sum;
                        end
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_TICK_RD;
                end
            end

            // cleanup pass, slot re-examined after each swap
            S_CLN_CHK:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_FIN;
                end
                else if (done_reg[idx_a])
                begin
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_kind       = pend_valid_reg ? K_FIRED : K_NONE;
                    push_id         = pend_valid_reg ? pend_id_reg : 8'd0;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_kind_reg <= push_kind;
            out_id_reg   <= push_id;
            out_last_reg <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign fired_id  = out_id_reg;
    assign last      = out_last_reg;

    // checks on the sequencer
    `PTTS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(TASKS), "task count above depth")
    `PTTS_ASSERT_IMPL(a_done_idle, state_reg == S_IDLE, done_reg == '0, "done bits left set")
    `PTTS_ASSERT_IMPL(a_report_bound, 1'b1, n_reg <= NW'(MAX_RESULTS), "too many fired words")
    `PTTS_ASSERT_NEXT(a_last_idle, push && push_last, state_reg == S_IDLE, "final word not idle")
    `PTTS_ASSERT_IMPL(a_push_room, push, out_free, "result pushed into full register")

endmodule

### hw/rtl/ptts_table.sv
// task table storage: one write port, one registered read port
// depends on ptts_pkg for the entry type
module ptts_table
    import ptts_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### verif/testbench.sv
// testbench for the periodic task table scheduler: directed and random words
// checked against a behavioural table model kept alongside the block
// depends on ptts_pkg and periodic_task_table_scheduler_unit
module testbench;
    import ptts_pkg::*;

    localparam int TASKS = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        kind_t      kind;
        logic [7:0] id;
        logic       last;
    } result_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_ADD;
    logic [7:0]  task_id = 8'd0;
    logic [14:0] period = 15'd0;
    logic        one_shot = 1'b0;
    logic [31:0] now = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  fired_id;
    logic        last;

    // copy of the task table kept by the testbench
    logic [7:0]  sched_id [TASKS];
    logic [14:0] sched_period [TASKS];
    logic        sched_one_shot [TASKS];
    logic [31:0] sched_due [TASKS];
    logic        sched_done [TASKS];
    int          sched_count = 0;

    result_word_t expected_words[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           stall_cycles = 0;
    logic [31:0]  sched_clock = 32'd0;

    periodic_task_table_scheduler_unit #(.TASKS(TASKS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .task_id   (task_id),
        .period    (period),
        .one_shot  (one_shot),
        .now       (now),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .fired_id  (fired_id),
        .last      (last)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // swap-with-last removal of one slot
    task automatic drop_entry(input int slot);
        if (sched_count > 0 && slot < sched_count)
        begin
            sched_id[slot]       = sched_id[sched_count - 1];
            sched_period[slot]   = sched_period[sched_count - 1];
            sched_one_shot[slot] = sched_one_shot[sched_count - 1];
            sched_due[slot]      = sched_due[sched_count - 1];
            sched_done[slot]     = sched_done[sched_count - 1];
            sched_count--;
        end
    endtask

    // work out the result words of one accepted input word
    task automatic predict_word(input logic [1:0] act, input logic [7:0] id,
                                input logic [14:0] per, input logic shot,
                                input logic [31:0] t);
        result_word_t fired[$];
        int           idx;
        logic         found;
        found = 1'b0;
        if (act == ACT_ADD)
        begin
            if (sched_count >= TASKS)
            begin
                expected_words.push_back('{kind: K_FULL, id: 8'd0, last: 1'b1});
            end
            else
            begin
                sched_id[sched_count]       = id;
                sched_period[sched_count]   = per;
                sched_one_shot[sched_count] = shot;
                sched_due[sched_count]      = {17'd0, per};
                sched_done[sched_count]     = 1'b0;
                sched_count++;
                expected_words.push_back('{kind: K_ADDED, id: id, last: 1'b1});
            end
        end
        else if (act == ACT_REMOVE)
        begin
            for (idx = 0; idx < sched_count && !found; idx++)
            begin
                if (sched_id[idx] == id)
                begin
                    drop_entry(idx);
                    found = 1'b1;
                end
            end
            if (found)
                expected_words.push_back('{kind: K_REMOVED, id: id, last: 1'b1});
            else
                expected_words.push_back('{kind: K_NOTFOUND, id: 8'd0, last: 1'b1});
        end
        else if (act == ACT_TICK)
        begin
            // walk the table in order
            for (idx = 0; idx < sched_count; idx++)
            begin
                if (!sched_done[idx] && (sched_period[idx] == 15'd0 || t > sched_due[idx]))
                begin
                    if (fired.size() < MAX_RESULTS)
                        fired.push_back('{kind: K_FIRED, id: sched_id[idx], last: 1'b0});
                    if (sched_one_shot[idx])
                        sched_done[idx] = 1'b1;
                    else if (sched_period[idx] == 15'd0)
                        sched_due[idx] = 32'd0;
                    else
                        sched_due[idx] = t + {17'd0, sched_period[idx]};
                end
            end
            // cleanup pass, slot looked at again after each swap
            idx = 0;
            while (idx < sched_count)
            begin
                if (sched_done[idx])
                    drop_entry(idx);
                else
                    idx++;
            end
            if (fired.size() == 0)
            begin
                expected_words.push_back('{kind: K_NONE, id: 8'd0, last: 1'b1});
            end
            else
            begin
                fired[fired.size() - 1].last = 1'b1;
                foreach (fired[k])
                    expected_words.push_back(fired[k]);
            end
        end
    endtask

    // offer one word and wait for it to be taken
    task automatic send_word(input logic [1:0] act, input logic [7:0] id,
                             input logic [14:0] per, input logic shot,
                             input logic [31:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        task_id  <= id;
        period   <= per;
        one_shot <= shot;
        now      <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(act, id, per, shot, t);
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word kind %0d id %0d last %0d",
                                          kind, fired_id, last));
            end
            else
            begin
                want = expected_words.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
                if (fired_id !== want.id)
                    report_mismatch($sformatf("fired_id %0d, wanted %0d", fired_id, want.id));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, wanted %0d", last, want.last));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // tick and remove on an empty table
    task automatic test_empty_table();
        send_word(ACT_TICK, 8'd0, 15'd0, 1'b0, 32'd0);
        send_word(ACT_REMOVE, 8'h55, 15'd0, 1'b0, 32'd0);
    endtask

    // unused action code with every field at its top
    task automatic test_unused_action();
        send_word(ACT_UNUSED, 8'hFF, 15'h7FFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    // fill the table, duplicate ids included, then one add too many
    task automatic test_table_full();
        int          k;
        logic [7:0]  id;
        logic [14:0] per;
        for (k = 0; k < TASKS; k++)
        begin
            id  = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : (k < 4) ? 8'h02 : 8'(k);
            per = (k == 0) ? 15'd0 : (k == 1) ? 15'h7FFF : 15'(k * 3);
            send_word(ACT_ADD, id, per, k[0], 32'd0);
        end
        send_word(ACT_ADD, 8'hAA, 15'd5, 1'b0, 32'd0);
    endtask

    // every entry fires at once and due times wrap, then two more ticks
    task automatic test_many_firings();
        send_word(ACT_TICK, 8'd0, 15'd0, 1'b0, 32'hFFFF_FFFF);
        send_word(ACT_TICK, 8'd0, 15'd0, 1'b0, 32'd0);
        send_word(ACT_TICK, 8'd0, 15'd0, 1'b0, 32'd10);
    endtask

    // remove of a present id, then of a missing id
    task automatic test_remove_cases();
        send_word(ACT_REMOVE, 8'h02, 15'd0, 1'b0, 32'd0);
        send_word(ACT_REMOVE, 8'h77, 15'd0, 1'b0, 32'd0);
    endtask

    // random mix of adds, removes mostly of live ids, and ticks with mostly advancing time
    task automatic test_random_traffic(input int count);
        int          sent;
        int          pick;
        logic [7:0]  id;
        logic [14:0] per;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 36)
            begin
                per = ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 60));
                send_word(ACT_ADD, 8'($urandom), per, 1'($urandom), 32'($urandom));
                sent++;
            end
            else if (pick < 60)
            begin
                if (sched_count > 0 && $urandom_range(0, 4) != 0)
                    id = sched_id[$urandom_range(0, sched_count - 1)];
                else
                    id = 8'($urandom);
                send_word(ACT_REMOVE, id, 15'($urandom), 1'($urandom), 32'($urandom));
                sent++;
            end
            else if (pick < 96)
            begin
                if ($urandom_range(0, 9) == 0)
                    sched_clock = $urandom;
                else
                    sched_clock = sched_clock + $urandom_range(0, 70);
                send_word(ACT_TICK, 8'($urandom), 15'($urandom), 1'($urandom), sched_clock);
                sent++;
            end
            else
            begin
                send_word(ACT_UNUSED, 8'($urandom), 15'($urandom), 1'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 65;
        test_empty_table();
        test_unused_action();
        test_table_full();
        test_many_firings();
        test_remove_cases();
        test_random_traffic(75);

        send_idle_pct = 65;
        recv_idle_pct = 32;
        test_random_traffic(75);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(75);
        in_valid <= 1'b0;

        // drain, then let the block settle
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_table.sv
hw/rtl/periodic_task_table_scheduler_unit.sv
verif/testbench.sv
